### hdl/range_min_sparse_table_top_defines.svh
// Assertion macros used by the controller of the range-minimum engine.
`ifndef RANGE_MIN_SPARSE_TABLE_TOP_DEFINES_SVH
`define RANGE_MIN_SPARSE_TABLE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rms_pkg.sv
// Shared types and constants of the range-minimum engine.
package rms_pkg;

  localparam int POS_W  = 10;  // query position field width
  localparam int VAL_W  = 32;  // element width
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int WIDE_W = 17;  // holds any element count and any level span
  localparam int K_W    = 4;   // raw query level before saturation

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the accepted input beat
    logic app_l0;    // write level 0, bump the count
    logic app_rd;    // read level below for the current level
    logic app_wr;    // write merged entry of the current level
    logic q_prep;    // work out query level and second start
    logic q_rd1;     // read span starting at lo
    logic q_rd2;     // read span ending at hi
    logic q_cmp;     // compare the two spans
    logic clr;       // empty the store
    logic set_full;
    logic set_bad;
    logic out_load;  // move the result into the output register
  } rms_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;  // store holds MAX_ELEMS elements
    logic            bad;   // upper query position not loaded
    logic            more;  // current level has an entry to refresh
  } rms_stat_t;

endpackage

### hdl/range_min_sparse_table_top.sv
// Range-minimum engine over an incrementally built sparse table.
//
// Input beats on in_*: in_tuser carries the operation (append, query,
// clear), in_tdata the append value and the two query positions.
// Every accepted beat gives exactly one result beat on out_*: out_tdata
// holds the minimum (zero for append and clear), out_tuser the status.
// One item is worked on at a time; in_tready is high only while idle.
// Clear, unused codes, a full store and a bad position go from decode
// straight to the result; a query reads two spans and compares them;
// an append writes level 0, then refreshes each level that has an entry.
// Each refreshed level takes one read and one write of the single table
// memory. The next beat can be accepted in the cycle after the result is
// loaded, also while that result still waits; a stalled receiver only
// holds the engine when a second result is ready to be loaded.
// Reset empties the store and drops out_tvalid; table contents are not
// cleared and are never read before they are written.
module range_min_sparse_table_top
  import rms_pkg::*;
#(
  parameter int MAX_ELEMS = 1024,
  parameter int LEVELS    = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // value[31:0], left_pos[41:32], right_pos[51:42], zero pad
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // min_value[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int LVC_W = $clog2(LEVELS + 1);

  rms_cmd_t         cmd;
  rms_stat_t        stat;
  logic [LVC_W-1:0] lvl;

  rms_ctrl #(
    .LEVELS(LEVELS),
    .LVC_W (LVC_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd),
    .lvl       (lvl)
  );

  rms_datapath #(
    .MAX_ELEMS(MAX_ELEMS),
    .LEVELS   (LEVELS),
    .LVC_W    (LVC_W)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_op     (in_tuser),
    .in_value  (in_tdata[31:0]),
    .in_left   (in_tdata[41:32]),
    .in_right  (in_tdata[51:42]),
    .cmd       (cmd),
    .lvl       (lvl),
    .stat      (stat),
    .out_min   (out_tdata),
    .out_status(out_tuser)
  );

endmodule

### hdl/rms_ctrl.sv
// Controller state machine of the range-minimum engine.
`include "range_min_sparse_table_top_defines.svh"
module rms_ctrl
  import rms_pkg::*;
#(
  parameter int LEVELS = 10,
  parameter int LVC_W  = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  rms_stat_t        stat,
  output rms_cmd_t         cmd,
  output logic [LVC_W-1:0] lvl
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_APP_RD = 4'd2;
  localparam logic [3:0] S_APP_WR = 4'd3;
  localparam logic [3:0] S_Q_RD1  = 4'd4;
  localparam logic [3:0] S_Q_RD2  = 4'd5;
  localparam logic [3:0] S_Q_CMP  = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;

  logic [3:0]       state_r, state_nxt;
  logic [LVC_W-1:0] lvl_r, lvl_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire;
  logic             slot_free;

  // no beat is taken while reset is held
  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;
  assign lvl        = lvl_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_APPEND: begin
            if (stat.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = S_FIN;
            end else begin
              cmd.app_l0 = 1'b1;
              lvl_nxt    = LVC_W'(1);
              state_nxt  = S_APP_RD;
            end
          end
          OP_QUERY: begin
            if (stat.bad) begin
              cmd.set_bad = 1'b1;
              state_nxt   = S_FIN;
            end else begin
              cmd.q_prep = 1'b1;
              state_nxt  = S_Q_RD1;
            end
          end
          OP_CLEAR: begin
            cmd.clr   = 1'b1;
            state_nxt = S_FIN;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_APP_RD: begin
        if (stat.more) begin
          cmd.app_rd = 1'b1;
          state_nxt  = S_APP_WR;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_APP_WR: begin
        cmd.app_wr = 1'b1;
        lvl_nxt    = lvl_r + LVC_W'(1);
        state_nxt  = S_APP_RD;
      end
      S_Q_RD1: begin
        cmd.q_rd1 = 1'b1;
        state_nxt = S_Q_RD2;
      end
      S_Q_RD2: begin
        cmd.q_rd2 = 1'b1;
        state_nxt = S_Q_CMP;
      end
      S_Q_CMP: begin
        cmd.q_cmp = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  `RMS_ASSERT_NEXT(a_accept_exec, in_fire, state_r == S_EXEC, "accepted beat not decoded")
  `RMS_ASSERT_NOW(a_wr_after_rd, state_r == S_APP_WR, $past(state_r) == S_APP_RD, "write without read")
  `RMS_ASSERT_NOW(a_lvl_range, state_r == S_APP_WR, lvl_r < LVC_W'(LEVELS), "level past table")
  `RMS_ASSERT_NOW(a_load_free, cmd.out_load, !out_valid_r || out_tready, "result overwritten")

endmodule

### hdl/rms_datapath.sv
// Datapath of the range-minimum engine: table memory, count, query arithmetic.
module rms_datapath
  import rms_pkg::*;
#(
  parameter int MAX_ELEMS = 1024,
  parameter int LEVELS    = 10,
  parameter int LVC_W     = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [OP_W-1:0]   in_op,
  input  logic [VAL_W-1:0]  in_value,
  input  logic [POS_W-1:0]  in_left,
  input  logic [POS_W-1:0]  in_right,
  input  rms_cmd_t          cmd,
  input  logic [LVC_W-1:0]  lvl,
  output rms_stat_t         stat,
  output logic [VAL_W-1:0]  out_min,
  output logic [ST_W-1:0]   out_status
);

  localparam int ADDR_W    = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int MEM_A_W   = LVL_W + ADDR_W;
  localparam int MEM_DEPTH = LEVELS << ADDR_W;

  // table memory, one row of 1 << ADDR_W words (at least MAX_ELEMS) per level
  logic [VAL_W-1:0] mem [MEM_DEPTH];

  logic [OP_W-1:0]    op_r;
  logic [VAL_W-1:0]   value_r;
  logic [POS_W-1:0]   lo_r, hi_r;
  logic [CNT_W-1:0]   count_r;
  logic [VAL_W-1:0]   cur_r;
  logic [VAL_W-1:0]   rd_data_r;
  logic [LVL_W-1:0]   k_r;
  logic [POS_W-1:0]   addr2_r;
  logic [VAL_W-1:0]   res_min_r;
  logic [ST_W-1:0]    res_status_r;
  logic [VAL_W-1:0]   out_min_r;
  logic [ST_W-1:0]    out_status_r;

  logic [WIDE_W-1:0]  count_w;
  logic [WIDE_W-1:0]  span_w;
  logic [ADDR_W-1:0]  app_j;
  logic [VAL_W-1:0]   merged;
  logic [POS_W-1:0]   pos_diff;
  logic [K_W-1:0]     k_raw;
  logic [K_W-1:0]     k_sat;
  logic [POS_W:0]     q_span;
  logic [POS_W:0]     q_start2;
  logic               rd_en, wr_en;
  logic [MEM_A_W-1:0] rd_addr, wr_addr;
  logic [VAL_W-1:0]   wr_data;

  // append refresh: entry of level lvl ending at the newest element
  assign count_w = WIDE_W'(count_r);
  assign span_w  = WIDE_W'(1) << lvl;
  assign app_j   = ADDR_W'(count_w - span_w);
  assign merged  = ($signed(rd_data_r) < $signed(cur_r)) ? rd_data_r : cur_r;

  assign stat.op   = op_r;
  assign stat.full = (count_r == CNT_W'(MAX_ELEMS));
  assign stat.bad  = (WIDE_W'(hi_r) >= count_w);
  assign stat.more = (lvl < LVC_W'(LEVELS)) && (count_w >= span_w);

  // query level: index of the top set bit of hi - lo, held to the last level
  assign pos_diff = hi_r - lo_r;
  always_comb begin
    k_raw = '0;
    for (int b = 0; b < POS_W; b++) begin
      if (pos_diff[b]) k_raw = K_W'(b);
    end
    k_sat = (k_raw > K_W'(LEVELS - 1)) ? K_W'(LEVELS - 1) : k_raw;
  end
  assign q_span   = (POS_W + 1)'(1) << k_sat;
  assign q_start2 = {1'b0, hi_r} + (POS_W + 1)'(1) - q_span;

  // memory port selection
  always_comb begin
    rd_en   = cmd.app_rd || cmd.q_rd1 || cmd.q_rd2;
    rd_addr = {k_r, ADDR_W'(addr2_r)};
    if (cmd.app_rd) begin
      rd_addr = {LVL_W'(lvl - LVC_W'(1)), app_j};
    end else if (cmd.q_rd1) begin
      rd_addr = {k_r, ADDR_W'(lo_r)};
    end
    wr_en   = cmd.app_l0 || cmd.app_wr;
    wr_addr = {LVL_W'(lvl), app_j};
    wr_data = merged;
    if (cmd.app_l0) begin
      wr_addr = {LVL_W'(0), ADDR_W'(count_r)};
      wr_data = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clr) begin
      count_r <= '0;
    end else if (cmd.app_l0) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // item, working and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r         <= in_op;
      value_r      <= in_value;
      lo_r         <= (in_left < in_right) ? in_left : in_right;
      hi_r         <= (in_left < in_right) ? in_right : in_left;
      res_min_r    <= '0;
      res_status_r <= ST_OK;
    end
    if (cmd.set_full) res_status_r <= ST_FULL;
    if (cmd.set_bad) res_status_r <= ST_BAD;
    if (cmd.app_l0) cur_r <= value_r;
    if (cmd.app_wr) cur_r <= merged;
    if (cmd.q_prep) begin
      k_r     <= LVL_W'(k_sat);
      addr2_r <= POS_W'(q_start2);
    end
    if (cmd.q_rd2) cur_r <= rd_data_r;
    if (cmd.q_cmp) res_min_r <= merged;
    if (cmd.out_load) begin
      out_min_r    <= res_min_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_min    = out_min_r;
  assign out_status = out_status_r;

endmodule
